// ----- src/bq_pkg.sv -----
// ---------------------------------------------------------------------------
// bq_pkg
// Shared widths, codes, control structs and arithmetic helpers for the
// multichannel transposed direct form II biquad.
// ---------------------------------------------------------------------------
package bq_pkg;

   localparam int CHANNELS    = 8;
   localparam int SAMPLE_BITS = 24;
   localparam int CHAN_W      = 3;
   localparam int CHAN_IDX_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;

   localparam int COEF_W      = 32;
   localparam int COEF_FRAC   = 27;
   localparam int STATE_W     = 48;
   localparam int STATE_FRAC  = 32;
   localparam int NUM_COEFS   = 5;
   localparam int CSR_IDX_W   = 3;

   // serial multiplier: coefficient consumed one digit per cycle
   localparam int DIGIT_W     = 8;
   localparam int DIGITS      = COEF_W / DIGIT_W;
   localparam int DIGIT_CNT_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
   localparam int ACC_W       = STATE_W + 2;
   localparam int PROD_W      = STATE_W + COEF_W;

   // product alignment to 32 fractional bits
   localparam int SAMPLE_SHIFT = SAMPLE_BITS - 1 + COEF_FRAC - STATE_FRAC;
   localparam int P_W          = SAMPLE_BITS + COEF_W - SAMPLE_SHIFT;
   localparam int Q_W          = STATE_W + COEF_W - COEF_FRAC;
   localparam int SUM_W        = STATE_W + 8;

   // output rounding
   localparam int RND_SHIFT = STATE_FRAC - (SAMPLE_BITS - 1);
   localparam int RND_W     = STATE_W + 1 - RND_SHIFT;

   localparam logic signed [SUM_W-1:0] SUM_STATE_MAX =
      SUM_W'((64'sd1 <<< (STATE_W - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] SUM_STATE_MIN = -SUM_STATE_MAX - SUM_W'(1);
   localparam logic signed [STATE_W:0] RND_HALF = (STATE_W + 1)'(64'sd1 <<< (RND_SHIFT - 1));
   localparam logic signed [RND_W-1:0] RND_SMAX =
      RND_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
   localparam logic signed [RND_W-1:0] RND_SMIN = -RND_SMAX - RND_W'(1);

   localparam logic [COEF_W-1:0] COEF_ONE = COEF_W'(64'd1 << COEF_FRAC);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_B0 = 3'd0,
      CSR_B1 = 3'd1,
      CSR_B2 = 3'd2,
      CSR_A1 = 3'd3,
      CSR_A2 = 3'd4
   } bq_csr_type;

   typedef struct packed {
      logic load;
      logic step;
      logic last;
   } bq_mul_ctl_type;

   typedef struct packed {
      logic ready;    // idle, input may be taken
      logic step;     // one coefficient digit this cycle
      logic last;     // top (signed) digit
      logic y_load;   // y is formed, feedback products start
      logic finish;   // write back state and hand off the result
   } bq_seq_type;

   function automatic logic signed [STATE_W-1:0] sat_state(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] t;
      t = v;
      if (v > SUM_STATE_MAX) t = SUM_STATE_MAX;
      if (v < SUM_STATE_MIN) t = SUM_STATE_MIN;
      return t[STATE_W-1:0];
   endfunction

   // round half up to SAMPLE_BITS-1 fraction bits, then saturate
   function automatic logic [SAMPLE_BITS-1:0] round_sample(input logic signed [STATE_W-1:0] y);
      logic signed [STATE_W:0] t;
      logic signed [RND_W-1:0] r;
      t = (STATE_W + 1)'(y) + RND_HALF;
      r = t[STATE_W:RND_SHIFT];
      if (r > RND_SMAX) r = RND_SMAX;
      if (r < RND_SMIN) r = RND_SMIN;
      return r[SAMPLE_BITS-1:0];
   endfunction

endpackage

// ----- src/bq_sermul.sv -----
// ---------------------------------------------------------------------------
// bq_sermul
// Serial-parallel multiplier: signed state-width operand times a signed
// coefficient taken one digit per cycle, low digit first.
// ---------------------------------------------------------------------------
module bq_sermul
   import bq_pkg::*;
(
   input  logic                       clock,
   input  bq_mul_ctl_type             ctl,
   input  logic signed [STATE_W-1:0]  mcand,
   input  logic [COEF_W-1:0]          mplier,
   output logic signed [PROD_W-1:0]   prod
);

   localparam int PART_W = STATE_W + DIGIT_W + 1;
   localparam int MS_W   = ACC_W + DIGIT_W;

   logic signed [STATE_W-1:0] a_ff, a_in;
   logic [COEF_W-1:0]         c_ff, c_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [COEF_W-1:0]         lo_ff, lo_in;

   logic signed [DIGIT_W:0]   dig;
   logic signed [PART_W-1:0]  part;
   logic signed [MS_W-1:0]    sum;

   // only the top digit carries the sign
   assign dig  = {c_ff[DIGIT_W-1] & ctl.last, c_ff[DIGIT_W-1:0]};
   assign part = PART_W'(a_ff) * PART_W'(dig);
   assign sum  = MS_W'(acc_ff) + MS_W'(part);

   always_comb begin
      a_in   = a_ff;
      c_in   = c_ff;
      acc_in = acc_ff;
      lo_in  = lo_ff;
      if (ctl.load) begin
         a_in   = mcand;
         c_in   = mplier;
         acc_in = '0;
         lo_in  = '0;
      end else if (ctl.step) begin
         c_in   = c_ff >> DIGIT_W;
         acc_in = sum[MS_W-1:DIGIT_W];
         lo_in  = {sum[DIGIT_W-1:0], lo_ff[COEF_W-1:DIGIT_W]};
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      c_ff   <= c_in;
      acc_ff <= acc_in;
      lo_ff  <= lo_in;
   end

   assign prod = {acc_ff[STATE_W-1:0], lo_ff};

endmodule

// ----- src/bq_seq.sv -----
// ---------------------------------------------------------------------------
// bq_seq
// Sequencer: feedforward digit pass, y formation, feedback digit pass,
// write-back.
// ---------------------------------------------------------------------------
module bq_seq
   import bq_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  logic       out_free,
   output bq_seq_type ctl
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MULX = 5'b00010,
      ST_YSUM = 5'b00100,
      ST_MULY = 5'b01000,
      ST_DONE = 5'b10000
   } bq_state_type;

   bq_state_type           state_ff, state_in;
   logic [DIGIT_CNT_W-1:0] cnt_ff, cnt_in;
   logic                   last;

   assign last = (cnt_ff == DIGIT_CNT_W'(DIGITS - 1));

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      ctl      = '0;
      case (state_ff)
         ST_IDLE: begin
            ctl.ready = 1'b1;
            cnt_in    = '0;
            if (start) state_in = ST_MULX;
         end
         ST_MULX: begin
            ctl.step = 1'b1;
            ctl.last = last;
            cnt_in   = cnt_ff + 1'b1;
            if (last) begin
               state_in = ST_YSUM;
               cnt_in   = '0;
            end
         end
         ST_YSUM: begin
            ctl.y_load = 1'b1;
            state_in   = ST_MULY;
         end
         ST_MULY: begin
            ctl.step = 1'b1;
            ctl.last = last;
            cnt_in   = cnt_ff + 1'b1;
            if (last) begin
               state_in = ST_DONE;
               cnt_in   = '0;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               ctl.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            cnt_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

// ----- src/biquad_tdf2_multichannel.sv -----
// ---------------------------------------------------------------------------
// biquad_tdf2_multichannel
// Second-order IIR section, transposed direct form II, with per-channel
// 48-bit delay state (32 fraction bits) and S4.27 coefficients.
// ---------------------------------------------------------------------------
//
//  port group | direction | beat contents
//  -----------+-----------+-------------------------------------------------
//  req_*      | in        | tdata: sample_in (24b signed); tuser: chan (3b)
//  rsp_*      | out       | tdata: sample_out (24b signed); tuser: chan_out
//  csr_*      | in        | write-only: index 0..4 = b0, b1, b2, a1, a2
//
//  One beat at a time: after its accept, a beat passes 4 feedforward digit
//  steps, 1 y sum, 4 feedback digit steps and 1 write-back before the next
//  accept is possible. The step count follows from the 8-bit coefficient
//  digits of the serial multipliers: 32-bit coefficients take 4 steps per
//  pass. The result is registered into the output register at write-back.
//  Reset (sync, high) clears the delay state, loads b0 = 1.0, others 0.
//  A stalled rsp_ holds the finished beat while the next req_ beat is taken
//  and processed; write-back waits until the output register is free.
//
//  y   = b0*x + s1
//  s1' = b1*x - a1*y + s2
//  s2' = b2*x - a2*y
//  Products are floored to 32 fraction bits, sums saturate to 48 bits.
// ---------------------------------------------------------------------------
module biquad_tdf2_multichannel
   import bq_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,

   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [TDATA_W-1:0]   req_tdata,    // [23:0] sample_in
   input  logic [CHAN_W-1:0]    req_tuser,    // [2:0] chan

   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [TDATA_W-1:0]   rsp_tdata,    // [23:0] sample_out
   output logic [CHAN_W-1:0]    rsp_tuser,    // [2:0] chan_out

   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEF_W-1:0]    csr_wdata
);

   // ---------------- coefficient registers ----------------
   logic [COEF_W-1:0] b0_ff, b1_ff, b2_ff, a1_ff, a2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_ff <= COEF_ONE;
         b1_ff <= '0;
         b2_ff <= '0;
         a1_ff <= '0;
         a2_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_B0:  b0_ff <= csr_wdata;
            CSR_B1:  b1_ff <= csr_wdata;
            CSR_B2:  b2_ff <= csr_wdata;
            CSR_A1:  a1_ff <= csr_wdata;
            CSR_A2:  a2_ff <= csr_wdata;
            default: ;   // unmapped index, dropped
         endcase
      end
   end

   // ---------------- sequencer ----------------
   bq_seq_type seq;
   logic       req_acc;
   logic       out_free;

   assign req_tready = seq.ready;
   assign req_acc    = req_tvalid & seq.ready;
   assign out_free   = ~rsp_tvalid | rsp_tready;

   bq_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (req_acc),
      .out_free (out_free),
      .ctl      (seq)
   );

   // ---------------- channel capture and delay state ----------------
   logic [CHAN_W-1:0]        chan_ff;
   logic [CHAN_IDX_W-1:0]    idx;
   logic                     chan_ok;
   logic signed [STATE_W-1:0] s1_ff [CHANNELS];
   logic signed [STATE_W-1:0] s2_ff [CHANNELS];
   logic signed [STATE_W-1:0] s1, s2;

   always_ff @(posedge clock) begin
      if (req_acc) chan_ff <= req_tuser;
   end

   assign idx     = chan_ff[CHAN_IDX_W-1:0];
   assign chan_ok = (int'(chan_ff) < CHANNELS);   // out-of-range channel: zero state
   assign s1      = chan_ok ? s1_ff[idx] : '0;
   assign s2      = chan_ok ? s2_ff[idx] : '0;

   // ---------------- serial multiplier lanes ----------------
   // lane 0: b0*x, then a1*y; lane 1: b1*x, then a2*y; lane 2: b2*x
   logic signed [SAMPLE_BITS-1:0] x_smp;
   logic signed [STATE_W-1:0]     x_ext;
   logic signed [STATE_W-1:0]     y;
   logic signed [STATE_W-1:0]     mc01;
   logic [COEF_W-1:0]             c0, c1;
   logic signed [PROD_W-1:0]      prod0, prod1, prod2;
   bq_mul_ctl_type                mctl01, mctl2;

   assign x_smp = req_tdata[SAMPLE_BITS-1:0];
   assign x_ext = STATE_W'(x_smp);
   assign mc01  = seq.y_load ? y : x_ext;
   assign c0    = seq.y_load ? a1_ff : b0_ff;
   assign c1    = seq.y_load ? a2_ff : b1_ff;

   assign mctl01 = '{load: req_acc | seq.y_load, step: seq.step, last: seq.last};
   assign mctl2  = '{load: req_acc, step: seq.step, last: seq.last};

   bq_sermul u_lane0 (
      .clock (clock), .ctl (mctl01), .mcand (mc01), .mplier (c0), .prod (prod0)
   );

   bq_sermul u_lane1 (
      .clock (clock), .ctl (mctl01), .mcand (mc01), .mplier (c1), .prod (prod1)
   );

   bq_sermul u_lane2 (
      .clock (clock), .ctl (mctl2), .mcand (x_ext), .mplier (b2_ff), .prod (prod2)
   );

   // ---------------- y, output rounding, feedforward hold ----------------
   logic signed [P_W-1:0]     p0, p1, p2;
   logic signed [P_W-1:0]     p1_ff, p2_ff;
   logic [SAMPLE_BITS-1:0]    rnd_ff;

   assign p0 = prod0[SAMPLE_SHIFT +: P_W];   // floor to 32 fraction bits
   assign p1 = prod1[SAMPLE_SHIFT +: P_W];
   assign p2 = prod2[SAMPLE_SHIFT +: P_W];
   assign y  = sat_state(SUM_W'(p0) + SUM_W'(s1));

   always_ff @(posedge clock) begin
      if (seq.y_load) begin
         p1_ff  <= p1;
         p2_ff  <= p2;
         rnd_ff <= round_sample(y);   // feedback keeps full-precision y
      end
   end

   // ---------------- state update ----------------
   logic signed [Q_W-1:0]     q1, q2;
   logic signed [STATE_W-1:0] n1, n2;

   assign q1 = prod0[COEF_FRAC +: Q_W];
   assign q2 = prod1[COEF_FRAC +: Q_W];
   assign n1 = sat_state(SUM_W'(p1_ff) - SUM_W'(q1) + SUM_W'(s2));
   assign n2 = sat_state(SUM_W'(p2_ff) - SUM_W'(q2));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            s1_ff[i] <= '0;
            s2_ff[i] <= '0;
         end
      end else if (seq.finish && chan_ok) begin
         s1_ff[idx] <= n1;
         s2_ff[idx] <= n2;
      end
   end

   // ---------------- output register ----------------
   logic                   rsp_valid_ff;
   logic [CHAN_W-1:0]      rsp_chan_ff;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (seq.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (seq.finish) begin
         rsp_chan_ff   <= chan_ff;
         rsp_sample_ff <= rnd_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_chan_ff;
   assign rsp_tdata  = TDATA_W'(rsp_sample_ff);

endmodule

// ----- src/bq_checker.sv -----
// ---------------------------------------------------------------------------
// bq_checker
// Port-level checks for the biquad: one beat in flight, held results.
// ---------------------------------------------------------------------------
module bq_checker
   import bq_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_tvalid,
   input logic                req_tready,
   input logic                rsp_tvalid,
   input logic                rsp_tready,
   input logic [TDATA_W-1:0]  rsp_tdata,
   input logic [CHAN_W-1:0]   rsp_tuser
);

   // nothing left over from before reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // input closes as soon as a beat is taken
   a_busy_next: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input still open after accept");

   // still busy when the sequencer reaches write-back
   a_busy_late: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##10 !req_tready)
      else $error("input reopened before write-back");

endmodule

bind biquad_tdf2_multichannel bq_checker u_bq_checker (.*);
